// ----- src/nearest_neighbour_resize_assert.svh -----
// assertion macros for the resize block
`ifndef NEAREST_NEIGHBOUR_RESIZE_ASSERT_SVH
`define NEAREST_NEIGHBOUR_RESIZE_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define NNR_ASSERT_IMP(name, ck, rs, ante, cons) \
  name: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("nnr: check failed");
// next-cycle implication
`define NNR_ASSERT_NXT(name, ck, rs, ante, cons) \
  name: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("nnr: check failed");
`else
`define NNR_ASSERT_IMP(name, ck, rs, ante, cons)
`define NNR_ASSERT_NXT(name, ck, rs, ante, cons)
`endif
`endif

// ----- src/nnr_pkg.sv -----
`default_nettype none
package nnr_pkg;

  // frame store geometry
  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int ADDR_W     = $clog2(MAX_WIDTH * MAX_HEIGHT);

  // field widths
  localparam int PIX_W   = 8;
  localparam int COORD_W = 8;
  localparam int SIZE_W  = 9;

  // mapping datapath
  localparam int PROD_W     = COORD_W + SIZE_W;
  localparam int DIV_STAGES = PROD_W;

  // queues
  localparam int MID_DEPTH = 4;
  localparam int MID_PTR_W = $clog2(MID_DEPTH);
  localparam int MID_CNT_W = $clog2(MID_DEPTH + 1);
  localparam int OUT_DEPTH = 4;
  localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
  localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

  // config registers
  localparam int REG_IDX_W = 2;
  localparam logic [REG_IDX_W-1:0] REG_SOURCE_WIDTH  = REG_IDX_W'(0);
  localparam logic [REG_IDX_W-1:0] REG_SOURCE_HEIGHT = REG_IDX_W'(1);
  localparam logic [REG_IDX_W-1:0] REG_TARGET_WIDTH  = REG_IDX_W'(2);
  localparam logic [REG_IDX_W-1:0] REG_TARGET_HEIGHT = REG_IDX_W'(3);
  localparam logic [SIZE_W-1:0]    SIZE_RESET        = SIZE_W'(256);

  // commands
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  typedef struct packed {
    logic               cmd;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic [PIX_W-1:0]   pixel_in;
  } item_t;

  typedef struct packed {
    logic [PIX_W-1:0]   pixel_out;
    logic [COORD_W-1:0] source_col;
    logic [COORD_W-1:0] source_row;
  } result_t;

  typedef struct packed {
    logic [SIZE_W-1:0] source_width;
    logic [SIZE_W-1:0] source_height;
    logic [SIZE_W-1:0] target_width;
    logic [SIZE_W-1:0] target_height;
  } sizes_t;

  // one memory operation between front and back
  typedef struct packed {
    logic               is_read;
    logic [ADDR_W-1:0]  addr;
    logic [PIX_W-1:0]   pixel;
    logic [COORD_W-1:0] scol;
    logic [COORD_W-1:0] srow;
  } op_t;

endpackage
`default_nettype wire

// ----- src/nnr_div.sv -----
`default_nettype none
// pipelined restoring divider, one quotient bit per stage
module nnr_div (
  input  logic                       clk,
  input  logic                       en,
  input  logic [nnr_pkg::PROD_W-1:0] dividend,
  input  logic [nnr_pkg::SIZE_W-1:0] divisor,
  output logic [nnr_pkg::PROD_W-1:0] quotient
);

  logic [nnr_pkg::SIZE_W-1:0] rem_q [nnr_pkg::DIV_STAGES-1];
  logic [nnr_pkg::PROD_W-1:0] dvd_q [nnr_pkg::DIV_STAGES-1];
  logic [nnr_pkg::PROD_W-1:0] quo_q [nnr_pkg::DIV_STAGES];

  logic [nnr_pkg::SIZE_W-1:0] s_rem [nnr_pkg::DIV_STAGES];
  logic [nnr_pkg::PROD_W-1:0] s_dvd [nnr_pkg::DIV_STAGES];
  logic [nnr_pkg::PROD_W-1:0] s_quo [nnr_pkg::DIV_STAGES];
  logic [nnr_pkg::SIZE_W:0]   trial [nnr_pkg::DIV_STAGES];
  logic                       fits  [nnr_pkg::DIV_STAGES];

  always_comb begin
    s_rem[0] = '0;
    s_dvd[0] = dividend;
    s_quo[0] = '0;
    for (int k = 1; k < nnr_pkg::DIV_STAGES; k++) begin
      s_rem[k] = rem_q[k-1];
      s_dvd[k] = dvd_q[k-1];
      s_quo[k] = quo_q[k-1];
    end
    for (int k = 0; k < nnr_pkg::DIV_STAGES; k++) begin
      trial[k] = {s_rem[k], s_dvd[k][nnr_pkg::PROD_W-1]};
      fits[k]  = (trial[k] >= {1'b0, divisor});
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < nnr_pkg::DIV_STAGES; k++) begin
        quo_q[k] <= {s_quo[k][nnr_pkg::PROD_W-2:0], fits[k]};
      end
      for (int k = 0; k < nnr_pkg::DIV_STAGES - 1; k++) begin
        // remainder stays below the divisor, so it fits the size width
        if (fits[k]) begin
          rem_q[k] <= nnr_pkg::SIZE_W'(trial[k] - {1'b0, divisor});
        end else begin
          rem_q[k] <= nnr_pkg::SIZE_W'(trial[k]);
        end
        dvd_q[k] <= {s_dvd[k][nnr_pkg::PROD_W-2:0], 1'b0};
      end
    end
  end

  assign quotient = quo_q[nnr_pkg::DIV_STAGES-1];

endmodule
`default_nettype wire

// ----- src/nnr_front.sv -----
`default_nettype none
`include "nearest_neighbour_resize_assert.svh"
// accepts items, maps read coordinates to source coordinates, forms memory ops
module nnr_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  nnr_pkg::item_t  item,
  output logic            full,
  input  nnr_pkg::sizes_t sizes,
  output logic            op_valid,
  output nnr_pkg::op_t    op,
  input  logic            queue_full
);

  typedef struct packed {
    logic                        is_read;
    logic [nnr_pkg::ADDR_W-1:0]  wr_addr;
    logic [nnr_pkg::PIX_W-1:0]   pixel;
  } side_t;

  function automatic logic [nnr_pkg::SIZE_W-1:0] src_size(
    input logic [nnr_pkg::SIZE_W-1:0] v,
    input int                         limit
  );
    if (v == '0) return nnr_pkg::SIZE_W'(1);
    if (32'(v) > 32'(limit)) return nnr_pkg::SIZE_W'(limit);
    return v;
  endfunction

  function automatic logic [nnr_pkg::SIZE_W-1:0] clamp_coord(
    input logic [nnr_pkg::PROD_W-1:0] q,
    input logic [nnr_pkg::SIZE_W-1:0] size
  );
    logic [nnr_pkg::SIZE_W-1:0] last;
    last = size - nnr_pkg::SIZE_W'(1);
    if (q > nnr_pkg::PROD_W'(last)) return last;
    return nnr_pkg::SIZE_W'(q);
  endfunction

  function automatic logic [nnr_pkg::ADDR_W-1:0] pixel_addr(
    input logic [nnr_pkg::SIZE_W-1:0] c,
    input logic [nnr_pkg::SIZE_W-1:0] r
  );
    return nnr_pkg::ADDR_W'(r) * nnr_pkg::ADDR_W'(nnr_pkg::MAX_WIDTH)
         + nnr_pkg::ADDR_W'(c);
  endfunction

  logic en;
  logic accept;
  logic in_range;

  logic [nnr_pkg::SIZE_W-1:0] sw;
  logic [nnr_pkg::SIZE_W-1:0] sh;
  logic [nnr_pkg::SIZE_W-1:0] tw;
  logic [nnr_pkg::SIZE_W-1:0] th;

  logic           s0_valid;
  nnr_pkg::item_t s0_item;

  logic                       s1_valid;
  side_t                      s1_side;
  logic [nnr_pkg::PROD_W-1:0] prod_col;
  logic [nnr_pkg::PROD_W-1:0] prod_row;

  logic [nnr_pkg::DIV_STAGES-1:0] dv_valid;
  side_t                          dv_side [nnr_pkg::DIV_STAGES];
  logic [nnr_pkg::PROD_W-1:0]     quo_col;
  logic [nnr_pkg::PROD_W-1:0]     quo_row;

  logic [nnr_pkg::SIZE_W-1:0] sc;
  logic [nnr_pkg::SIZE_W-1:0] sr;
  side_t                      last_side;

  // whole front advances together; only the op stage can be blocked
  assign en     = !op_valid || !queue_full;
  assign full   = !en;
  assign accept = push && en;

  assign in_range = (32'(item.col) < 32'(nnr_pkg::MAX_WIDTH))
                 && (32'(item.row) < 32'(nnr_pkg::MAX_HEIGHT));

  assign sw = src_size(sizes.source_width, nnr_pkg::MAX_WIDTH);
  assign sh = src_size(sizes.source_height, nnr_pkg::MAX_HEIGHT);
  assign tw = (sizes.target_width == '0) ? nnr_pkg::SIZE_W'(1) : sizes.target_width;
  assign th = (sizes.target_height == '0) ? nnr_pkg::SIZE_W'(1) : sizes.target_height;

  // input stage, writes outside the store are dropped here
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (en) begin
      s0_valid <= accept && ((item.cmd == nnr_pkg::CMD_READ) || in_range);
    end
    if (en) begin
      s0_item <= item;
    end
  end

  // multiply stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= s0_valid;
    end
    if (en) begin
      prod_col        <= nnr_pkg::PROD_W'(s0_item.col) * nnr_pkg::PROD_W'(sw);
      prod_row        <= nnr_pkg::PROD_W'(s0_item.row) * nnr_pkg::PROD_W'(sh);
      s1_side.is_read <= (s0_item.cmd == nnr_pkg::CMD_READ);
      s1_side.wr_addr <= pixel_addr(nnr_pkg::SIZE_W'(s0_item.col),
                                    nnr_pkg::SIZE_W'(s0_item.row));
      s1_side.pixel   <= s0_item.pixel_in;
    end
  end

  nnr_div u_div_col (
    .clk      (clk),
    .en       (en),
    .dividend (prod_col),
    .divisor  (tw),
    .quotient (quo_col)
  );

  nnr_div u_div_row (
    .clk      (clk),
    .en       (en),
    .dividend (prod_row),
    .divisor  (th),
    .quotient (quo_row)
  );

  // sideband follows the divider stages
  always_ff @(posedge clk) begin
    if (rst) begin
      dv_valid <= '0;
    end else if (en) begin
      dv_valid <= {dv_valid[nnr_pkg::DIV_STAGES-2:0], s1_valid};
    end
    if (en) begin
      dv_side[0] <= s1_side;
      for (int k = 1; k < nnr_pkg::DIV_STAGES; k++) begin
        dv_side[k] <= dv_side[k-1];
      end
    end
  end

  assign last_side = dv_side[nnr_pkg::DIV_STAGES-1];
  assign sc        = clamp_coord(quo_col, sw);
  assign sr        = clamp_coord(quo_row, sh);

  // op stage
  always_ff @(posedge clk) begin
    if (rst) begin
      op_valid <= 1'b0;
    end else if (en) begin
      op_valid <= dv_valid[nnr_pkg::DIV_STAGES-1];
    end
    if (en) begin
      op.is_read <= last_side.is_read;
      op.addr    <= last_side.is_read ? pixel_addr(sc, sr) : last_side.wr_addr;
      op.pixel   <= last_side.pixel;
      op.scol    <= nnr_pkg::COORD_W'(sc);
      op.srow    <= nnr_pkg::COORD_W'(sr);
    end
  end

  `NNR_ASSERT_NXT(a_op_holds_when_blocked, clk, rst, op_valid && queue_full, op_valid && $stable(op))

endmodule
`default_nettype wire

// ----- src/nnr_queue.sv -----
`default_nettype none
`include "nearest_neighbour_resize_assert.svh"
// short op queue between front and back
module nnr_queue (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  nnr_pkg::op_t din,
  output logic         full,
  input  logic         pop,
  output logic         empty,
  output nnr_pkg::op_t dout
);

  nnr_pkg::op_t                  entries [nnr_pkg::MID_DEPTH];
  logic [nnr_pkg::MID_PTR_W-1:0] wr_ptr;
  logic [nnr_pkg::MID_PTR_W-1:0] rd_ptr;
  logic [nnr_pkg::MID_CNT_W-1:0] count;

  function automatic logic [nnr_pkg::MID_PTR_W-1:0] ptr_inc(
    input logic [nnr_pkg::MID_PTR_W-1:0] p
  );
    if (p == nnr_pkg::MID_PTR_W'(nnr_pkg::MID_DEPTH - 1)) return '0;
    return p + nnr_pkg::MID_PTR_W'(1);
  endfunction

  assign full  = (count == nnr_pkg::MID_CNT_W'(nnr_pkg::MID_DEPTH));
  assign empty = (count == '0);
  assign dout  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + nnr_pkg::MID_CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - nnr_pkg::MID_CNT_W'(1);
      end
    end
    if (push) begin
      entries[wr_ptr] <= din;
    end
  end

  `NNR_ASSERT_IMP(a_no_pop_when_empty, clk, rst, pop, count != '0)
  `NNR_ASSERT_IMP(a_no_push_when_full, clk, rst, push, count != nnr_pkg::MID_CNT_W'(nnr_pkg::MID_DEPTH))

endmodule
`default_nettype wire

// ----- src/nnr_back.sv -----
`default_nettype none
`include "nearest_neighbour_resize_assert.svh"
// frame store access and result queue
module nnr_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_empty,
  input  nnr_pkg::op_t     q_head,
  output logic             q_pop,
  output logic             empty,
  input  logic             pop,
  output nnr_pkg::result_t result
);

  logic [nnr_pkg::PIX_W-1:0] frame [nnr_pkg::MAX_WIDTH * nnr_pkg::MAX_HEIGHT];

  logic                        rd_valid;
  logic [nnr_pkg::PIX_W-1:0]   rd_pixel;
  logic [nnr_pkg::COORD_W-1:0] rd_col;
  logic [nnr_pkg::COORD_W-1:0] rd_row;

  nnr_pkg::result_t              out_mem [nnr_pkg::OUT_DEPTH];
  logic [nnr_pkg::OUT_PTR_W-1:0] out_wr_ptr;
  logic [nnr_pkg::OUT_PTR_W-1:0] out_rd_ptr;
  logic [nnr_pkg::OUT_CNT_W-1:0] out_count;
  logic [nnr_pkg::OUT_CNT_W-1:0] reserve;
  logic                          room;
  logic                          rd_issue;
  logic                          wr_issue;
  logic                          out_push;
  logic                          out_pop;

  function automatic logic [nnr_pkg::OUT_PTR_W-1:0] ptr_inc(
    input logic [nnr_pkg::OUT_PTR_W-1:0] p
  );
    if (p == nnr_pkg::OUT_PTR_W'(nnr_pkg::OUT_DEPTH - 1)) return '0;
    return p + nnr_pkg::OUT_PTR_W'(1);
  endfunction

  // a read goes out only when its result has a slot waiting
  assign reserve  = out_count + nnr_pkg::OUT_CNT_W'(rd_valid);
  assign room     = (reserve < nnr_pkg::OUT_CNT_W'(nnr_pkg::OUT_DEPTH));
  assign q_pop    = !q_empty && (!q_head.is_read || room);
  assign rd_issue = q_pop && q_head.is_read;
  assign wr_issue = q_pop && !q_head.is_read;

  always_ff @(posedge clk) begin
    if (wr_issue) begin
      frame[q_head.addr] <= q_head.pixel;
    end
    if (rd_issue) begin
      rd_pixel <= frame[q_head.addr];
      rd_col   <= q_head.scol;
      rd_row   <= q_head.srow;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= rd_issue;
    end
  end

  assign out_push = rd_valid;
  assign out_pop  = pop && !empty;
  assign empty    = (out_count == '0);
  assign result   = out_mem[out_rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_wr_ptr <= '0;
      out_rd_ptr <= '0;
      out_count  <= '0;
    end else begin
      if (out_push) begin
        out_wr_ptr <= ptr_inc(out_wr_ptr);
      end
      if (out_pop) begin
        out_rd_ptr <= ptr_inc(out_rd_ptr);
      end
      if (out_push && !out_pop) begin
        out_count <= out_count + nnr_pkg::OUT_CNT_W'(1);
      end else if (out_pop && !out_push) begin
        out_count <= out_count - nnr_pkg::OUT_CNT_W'(1);
      end
    end
    if (out_push) begin
      out_mem[out_wr_ptr].pixel_out  <= rd_pixel;
      out_mem[out_wr_ptr].source_col <= rd_col;
      out_mem[out_wr_ptr].source_row <= rd_row;
    end
  end

  `NNR_ASSERT_IMP(a_result_has_slot, clk, rst, rd_valid, out_count != nnr_pkg::OUT_CNT_W'(nnr_pkg::OUT_DEPTH))

endmodule
`default_nettype wire

// ----- src/nearest_neighbour_resize.sv -----
// nearest-neighbor scaler for 8-bit gray images with its own source frame store
// input channel: push/full, a transaction moves one item (cmd, col, row, pixel_in)
//   cmd write stores pixel_in at source (col, row); writes outside the store are dropped
//   cmd read names a destination pixel; it maps to source col*sw/tw, row*sh/th,
//   clamped to size - 1, and returns the stored pixel with those coordinates
// result channel: empty/pop, one transaction per read, none per write, in item order
// config: cfg_write with cfg_index/cfg_data, taken at once; the user writes only while
//   the block is idle; the block itself leaves this unchecked
// throughput: one item per cycle while full stays low; the 17-stage bit-per-stage
//   dividers are pipelined and the single-port frame store takes one access per cycle
// a read never sees a later write: every item reaches the frame store in order
// when pop stays low the result queue fills, reads wait at the store, the op queue
//   fills and full rises; no transaction is lost
// reset clears all valids and queues and sets every size register to 256;
//   the frame store is not cleared, so a pixel must be written before it is read
`default_nettype none
module nearest_neighbour_resize (
  input  logic                          clk,
  input  logic                          rst,
  // item side
  input  logic                          push,
  input  nnr_pkg::item_t                item,
  output logic                          full,
  // result side
  output logic                          empty,
  input  logic                          pop,
  output nnr_pkg::result_t              result,
  // config writes
  input  logic                          cfg_write,
  input  logic [nnr_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [nnr_pkg::SIZE_W-1:0]    cfg_data
);

  nnr_pkg::sizes_t sizes;

  logic         op_valid;
  nnr_pkg::op_t op;
  logic         mid_full;
  logic         mid_empty;
  logic         mid_pop;
  nnr_pkg::op_t mid_head;

  // size registers, raw values; zero and oversize handling lives in the front
  always_ff @(posedge clk) begin
    if (rst) begin
      sizes.source_width  <= nnr_pkg::SIZE_RESET;
      sizes.source_height <= nnr_pkg::SIZE_RESET;
      sizes.target_width  <= nnr_pkg::SIZE_RESET;
      sizes.target_height <= nnr_pkg::SIZE_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        nnr_pkg::REG_SOURCE_WIDTH:  sizes.source_width  <= cfg_data;
        nnr_pkg::REG_SOURCE_HEIGHT: sizes.source_height <= cfg_data;
        nnr_pkg::REG_TARGET_WIDTH:  sizes.target_width  <= cfg_data;
        nnr_pkg::REG_TARGET_HEIGHT: sizes.target_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // front: accept, coordinate mapping, op forming
  nnr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .item       (item),
    .full       (full),
    .sizes      (sizes),
    .op_valid   (op_valid),
    .op         (op),
    .queue_full (mid_full)
  );

  // decouples the mapping pipeline from the frame store
  nnr_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (op_valid && !mid_full),
    .din   (op),
    .full  (mid_full),
    .pop   (mid_pop),
    .empty (mid_empty),
    .dout  (mid_head)
  );

  // back: frame store and result queue
  nnr_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (mid_empty),
    .q_head  (mid_head),
    .q_pop   (mid_pop),
    .empty   (empty),
    .pop     (pop),
    .result  (result)
  );

endmodule
`default_nettype wire

// ----- tb/nearest_neighbour_resize_tb.sv -----
module nearest_neighbour_resize_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // cycles from the accepting edge until a read's result shows up
  localparam int LATENCY = 22;
  localparam int DRAIN_CYCLES = LATENCY + 10;
  localparam int ITEMS_PER_PHASE = 150;
  localparam int NUM_PHASES = 10;

  // shadow of the scaler: its own frame store, size registers and pending reads
  class ResizeScoreboard;
    bit [nnr_pkg::PIX_W-1:0] frame [nnr_pkg::MAX_WIDTH * nnr_pkg::MAX_HEIGHT];
    bit written [nnr_pkg::MAX_WIDTH * nnr_pkg::MAX_HEIGHT];
    bit [nnr_pkg::SIZE_W-1:0] size_reg [4];
    int unsigned src_cols, src_rows, dst_cols, dst_rows;
    nnr_pkg::result_t pending_pixels[$];
    int errors;

    function new();
      foreach (size_reg[i]) size_reg[i] = nnr_pkg::SIZE_RESET;
      errors = 0;
      refresh_sizes();
    endfunction

    // zero acts as one, source sizes stop at the store's size
    function int unsigned eff_size(bit [nnr_pkg::SIZE_W-1:0] r, int unsigned limit);
      if (r == '0) return 1;
      if (32'(r) > limit) return limit;
      return 32'(r);
    endfunction

    function void refresh_sizes();
      src_cols = eff_size(size_reg[nnr_pkg::REG_SOURCE_WIDTH], nnr_pkg::MAX_WIDTH);
      src_rows = eff_size(size_reg[nnr_pkg::REG_SOURCE_HEIGHT], nnr_pkg::MAX_HEIGHT);
      dst_cols = eff_size(size_reg[nnr_pkg::REG_TARGET_WIDTH], 511);
      dst_rows = eff_size(size_reg[nnr_pkg::REG_TARGET_HEIGHT], 511);
    endfunction

    function void set_size(logic [nnr_pkg::REG_IDX_W-1:0] idx,
                           bit [nnr_pkg::SIZE_W-1:0] value);
      size_reg[idx] = value;
      refresh_sizes();
    endfunction

    // floor(dst * src / dst_size), clamped to src - 1
    function int unsigned scale_coord(int unsigned dst, int unsigned src,
                                      int unsigned dsize);
      int unsigned q;
      q = (dst * src) / dsize;
      return (q > src - 1) ? src - 1 : q;
    endfunction

    function void locate(bit [nnr_pkg::COORD_W-1:0] col, bit [nnr_pkg::COORD_W-1:0] row,
                         output int unsigned sc, output int unsigned sr);
      sc = scale_coord(32'(col), src_cols, dst_cols);
      sr = scale_coord(32'(row), src_rows, dst_rows);
    endfunction

    // called at the edge where the input transaction is accepted
    function void note_item(nnr_pkg::item_t it);
      int unsigned sc, sr;
      int unsigned idx;
      nnr_pkg::result_t r;
      if (it.cmd == nnr_pkg::CMD_WRITE) begin
        idx = 32'(it.row) * nnr_pkg::MAX_WIDTH + 32'(it.col);
        frame[idx] = it.pixel_in;
        written[idx] = 1'b1;
      end else begin
        locate(it.col, it.row, sc, sr);
        r.pixel_out  = frame[sr * nnr_pkg::MAX_WIDTH + sc];
        r.source_col = sc[nnr_pkg::COORD_W-1:0];
        r.source_row = sr[nnr_pkg::COORD_W-1:0];
        pending_pixels.push_back(r);
      end
    endfunction

    function void check_result(nnr_pkg::result_t got);
      nnr_pkg::result_t want;
      if (pending_pixels.size() == 0) begin
        $error("result with nothing pending: pixel_out %0d source_col %0d source_row %0d",
               got.pixel_out, got.source_col, got.source_row);
        errors++;
        return;
      end
      want = pending_pixels.pop_front();
      if (got.pixel_out !== want.pixel_out) begin
        $error("pixel_out expected %0d actual %0d", want.pixel_out, got.pixel_out);
        errors++;
      end
      if (got.source_col !== want.source_col) begin
        $error("source_col expected %0d actual %0d", want.source_col, got.source_col);
        errors++;
      end
      if (got.source_row !== want.source_row) begin
        $error("source_row expected %0d actual %0d", want.source_row, got.source_row);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  nnr_pkg::item_t item = '0;
  logic full;
  logic empty;
  logic pop = 1'b0;
  nnr_pkg::result_t result;
  logic cfg_write = 1'b0;
  logic [nnr_pkg::REG_IDX_W-1:0] cfg_index = '0;
  logic [nnr_pkg::SIZE_W-1:0] cfg_data = '0;

  ResizeScoreboard sb = new();

  // when set, neither side idles
  bit steady = 1'b0;
  int sink_hold = 0;

  nearest_neighbour_resize dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .item      (item),
    .full      (full),
    .empty     (empty),
    .pop       (pop),
    .result    (result),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // idle length: mostly none or short, now and then long
  function automatic int idle_len();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 65) return 0;
    if (pick < 88) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 12);
    return $urandom_range(30, 80);
  endfunction

  // result side: take a transaction on pop && !empty, stall at random
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) sb.check_result(result);
      if (sink_hold > 0) begin
        sink_hold--;
        pop <= 1'b0;
      end else begin
        sink_hold = steady ? 0 : idle_len();
        pop <= (sink_hold == 0);
      end
    end
  end

  // one input transaction, then an optional gap on the item side
  task automatic push_item(nnr_pkg::item_t it);
    int gap;
    push <= 1'b1;
    item <= it;
    @(posedge clk);
    while (full) @(posedge clk);
    sb.note_item(it);
    gap = steady ? 0 : idle_len();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // a read of a source pixel that was never stored is kept out of the stimulus:
  // the pixel is written first with a random value
  task automatic read_pixel(bit [nnr_pkg::COORD_W-1:0] col, bit [nnr_pkg::COORD_W-1:0] row);
    int unsigned sc, sr;
    nnr_pkg::item_t it;
    sb.locate(col, row, sc, sr);
    if (!sb.written[sr * nnr_pkg::MAX_WIDTH + sc]) begin
      it.cmd = nnr_pkg::CMD_WRITE;
      it.col = sc[nnr_pkg::COORD_W-1:0];
      it.row = sr[nnr_pkg::COORD_W-1:0];
      it.pixel_in = nnr_pkg::PIX_W'($urandom_range(0, 255));
      push_item(it);
    end
    it.cmd = nnr_pkg::CMD_READ;
    it.col = col;
    it.row = row;
    it.pixel_in = nnr_pkg::PIX_W'($urandom_range(0, 255));
    push_item(it);
  endtask

  // idle the item side until every result is back, then let writes settle
  task automatic drain();
    push <= 1'b0;
    @(posedge clk);
    while (sb.pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // all four size registers, one write per cycle, block idle
  task automatic write_sizes(int unsigned sw, int unsigned sh, int unsigned tw,
                             int unsigned th);
    int unsigned vals [4];
    vals = '{sw, sh, tw, th};
    for (int i = 0; i < 4; i++) begin
      cfg_write <= 1'b1;
      cfg_index <= i[nnr_pkg::REG_IDX_W-1:0];
      cfg_data <= vals[i][nnr_pkg::SIZE_W-1:0];
      sb.set_size(i[nnr_pkg::REG_IDX_W-1:0], vals[i][nnr_pkg::SIZE_W-1:0]);
      @(posedge clk);
    end
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  // destination coordinate: mostly inside the target, some anywhere, some at the ends
  function automatic bit [nnr_pkg::COORD_W-1:0] pick_dst(int unsigned dsize);
    int pick;
    int unsigned top;
    pick = $urandom_range(0, 99);
    top = (dsize > 256) ? 255 : dsize - 1;
    if (pick < 78) return nnr_pkg::COORD_W'($urandom_range(0, top));
    if (pick < 90) return nnr_pkg::COORD_W'($urandom_range(0, 255));
    return ($urandom_range(0, 1) != 0) ? 8'd255 : 8'd0;
  endfunction

  task automatic random_items(int n);
    nnr_pkg::item_t it;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 99) < 45) begin
        // writes mostly land in the source image so that reads find them
        it.cmd = nnr_pkg::CMD_WRITE;
        if ($urandom_range(0, 99) < 85) begin
          it.col = nnr_pkg::COORD_W'($urandom_range(0, sb.src_cols - 1));
          it.row = nnr_pkg::COORD_W'($urandom_range(0, sb.src_rows - 1));
        end else begin
          it.col = nnr_pkg::COORD_W'($urandom_range(0, 255));
          it.row = nnr_pkg::COORD_W'($urandom_range(0, 255));
        end
        it.pixel_in = nnr_pkg::PIX_W'($urandom_range(0, 255));
        push_item(it);
      end else begin
        read_pixel(pick_dst(sb.dst_cols), pick_dst(sb.dst_rows));
      end
    end
  endtask

  function automatic int unsigned random_size();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 8) return 0;
    if (pick < 30) return $urandom_range(1, 8);
    if (pick < 85) return $urandom_range(1, 256);
    return $urandom_range(257, 511);
  endfunction

  initial begin
    int unsigned plan [6][4];
    nnr_pkg::item_t it;
    bit [nnr_pkg::COORD_W-1:0] corner_col [5];
    bit [nnr_pkg::COORD_W-1:0] corner_row [5];
    bit [nnr_pkg::PIX_W-1:0] corner_pix [5];

    // fixed settings: reset value, all zero (acts as one), one-pixel source,
    // oversized registers, shrink to one pixel, odd ratio with target above 256
    plan = '{'{256, 256, 256, 256}, '{0, 0, 0, 0}, '{1, 1, 256, 256},
             '{511, 511, 511, 511}, '{256, 256, 1, 1}, '{16, 9, 300, 200}};
    corner_col = '{8'd0, 8'd255, 8'd255, 8'd0, 8'd128};
    corner_row = '{8'd0, 8'd255, 8'd0, 8'd255, 8'd64};
    corner_pix = '{8'h00, 8'hff, 8'haa, 8'h55, 8'h3c};

    rst = 1'b1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph < 6)
        write_sizes(plan[ph][0], plan[ph][1], plan[ph][2], plan[ph][3]);
      else
        write_sizes(random_size(), random_size(), random_size(), random_size());

      if (ph == 0) begin
        // directed: corners and a middle pixel, written then read back with
        // junk in pixel_in; then an overwrite read at once
        for (int i = 0; i < 5; i++) begin
          it.cmd = nnr_pkg::CMD_WRITE;
          it.col = corner_col[i];
          it.row = corner_row[i];
          it.pixel_in = corner_pix[i];
          push_item(it);
        end
        for (int i = 0; i < 5; i++) begin
          it.cmd = nnr_pkg::CMD_READ;
          it.col = corner_col[i];
          it.row = corner_row[i];
          it.pixel_in = ~corner_pix[i];
          push_item(it);
        end
        it.cmd = nnr_pkg::CMD_WRITE;
        it.col = 8'd0;
        it.row = 8'd0;
        it.pixel_in = 8'h81;
        push_item(it);
        it.cmd = nnr_pkg::CMD_READ;
        it.pixel_in = 8'hff;
        push_item(it);
        steady = 1'b0;
      end else begin
        steady = ($urandom_range(0, 3) == 0);
      end

      random_items(ITEMS_PER_PHASE);
      drain();
      steady = 1'b0;
    end

    if (sb.errors == 0 && sb.pending_pixels.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // hang guard, far beyond the slowest correct run
  initial begin
    #(10_000_000);
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+src
src/nnr_pkg.sv
src/nnr_div.sv
src/nnr_front.sv
src/nnr_queue.sv
src/nnr_back.sv
src/nearest_neighbour_resize.sv
tb/nearest_neighbour_resize_tb.sv
